### src/acf_pkg.sv
// shared types and constants of the accumulator machine
// used by the front, the queue, the back, the top level and the checker
package acf_pkg;

	localparam int WORD_W     = 32;
	localparam int CELL_AW    = 10;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 104;
	localparam int QUEUE_DEPTH = 2;

	// opcode words
	localparam logic [WORD_W-1:0] OP_EXIT      = 32'd0;
	localparam logic [WORD_W-1:0] OP_LOAD_ARG  = 32'd1;
	localparam logic [WORD_W-1:0] OP_AC_MBR    = 32'd2;
	localparam logic [WORD_W-1:0] OP_AC_MAR    = 32'd3;
	localparam logic [WORD_W-1:0] OP_MBR_AC    = 32'd4;
	localparam logic [WORD_W-1:0] OP_MAR_AC    = 32'd5;
	localparam logic [WORD_W-1:0] OP_MEM_LOAD  = 32'd6;
	localparam logic [WORD_W-1:0] OP_MEM_STORE = 32'd7;
	localparam logic [WORD_W-1:0] OP_ADD       = 32'd8;
	localparam logic [WORD_W-1:0] OP_MUL       = 32'd9;
	localparam logic [WORD_W-1:0] OP_AND       = 32'd10;
	localparam logic [WORD_W-1:0] OP_OR        = 32'd11;
	localparam logic [WORD_W-1:0] OP_JUMP_NZ   = 32'd12;
	localparam logic [WORD_W-1:0] OP_NOP       = 32'd13;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FETCH   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_LOAD    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_STORE   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd4;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// classified request as it travels through the queue
	typedef struct packed {
		logic               is_step;
		logic               wr_ok;
		logic [CELL_AW-1:0] addr;
		logic [WORD_W-1:0]  opc;
		logic [WORD_W-1:0]  arg;
	} acf_req_t;

	// one result
	typedef struct packed {
		logic                halted;
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   op;
		logic [WORD_W-1:0]   pc;
		logic [WORD_W-1:0]   acc;
	} acf_res_t;

	// flow control seen by the front
	typedef struct packed {
		logic queue_full;
		logic clearing;
	} acf_front_ctl_t;

endpackage

### src/acf_front.sv
// front end: accepts requests from the input stream and classifies them
// depends on acf_pkg
module acf_front #(
	parameter int MEM_CELLS = 1024
) (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: cell_address[9:0], cell_opcode[41:10], cell_argument[73:42], zero pad
	input  logic [acf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: req_type[0]
	input  logic [0:0]                     s_axis_tuser,
	input  acf_pkg::acf_front_ctl_t        ctl,
	output logic                           push,
	output acf_pkg::acf_req_t              req
);
	import acf_pkg::*;

	logic [CELL_AW-1:0] addr;

	// take a request only when the queue has room and the store is cleared
	assign s_axis_tready = !ctl.queue_full && !ctl.clearing;
	assign push          = s_axis_tvalid && s_axis_tready;

	// unpack and flag cell writes that fall beyond the store
	assign addr        = s_axis_tdata[CELL_AW-1:0];
	assign req.is_step = (s_axis_tuser[0] == REQ_STEP);
	assign req.wr_ok   = (32'(addr) < 32'(MEM_CELLS));
	assign req.addr    = addr;
	assign req.opc     = s_axis_tdata[CELL_AW +: WORD_W];
	assign req.arg     = s_axis_tdata[CELL_AW + WORD_W +: WORD_W];

endmodule

### src/acf_fifo.sv
// short request queue between the front and the back
// depends on acf_pkg
module acf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acf_pkg::acf_req_t push_req,
	input  logic              pop,
	output acf_pkg::acf_req_t head,
	output logic              full,
	output logic              empty
);
	import acf_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	acf_req_t        entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_req;
	end

endmodule

### src/acf_back.sv
// back end: cell store, machine registers, fetch-execute sequencer and result register
// depends on acf_pkg
module acf_back #(
	parameter int MEM_CELLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [acf_pkg::CELL_AW-1:0] cfg_wdata,
	input  acf_pkg::acf_req_t           head,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        clearing,
	output logic                        res_valid,
	input  logic                        res_ready,
	output acf_pkg::acf_res_t           res
);
	import acf_pkg::*;

	localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} back_state_t;

	back_state_t        state_q, state_d;
	logic [AW-1:0]      clr_cnt_q;
	logic [CELL_AW-1:0] base_q;
	logic [WORD_W-1:0]  pc_q, acc_q, mar_q, mbr_q;
	logic [WORD_W-1:0]  pc_d, acc_d, mar_d, mbr_d;

	// cell store
	logic [WORD_W-1:0]  opc_mem [MEM_CELLS];
	logic [WORD_W-1:0]  arg_mem [MEM_CELLS];
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [WORD_W-1:0]  mem_wd_opc, mem_wd_arg;
	logic               issue;
	logic [WORD_W-1:0]  rd_op_q, rd_arg_q, rd_dat_q;

	// result register
	logic               out_valid_q;
	acf_res_t           out_q;
	logic               out_free;
	logic               res_load;
	acf_res_t           res_d;

	logic [WORD_W+1:0]  fetch_sum;
	logic               fetch_ok;
	logic               mar_ok;
	logic [WORD_W-1:0]  mul_lo;
	logic               advance;

	// fetch address is base plus signed counter
	assign fetch_sum = {24'd0, base_q} + {{2{pc_q[WORD_W-1]}}, pc_q};
	assign fetch_ok  = !fetch_sum[WORD_W+1] && (fetch_sum < (WORD_W+2)'(MEM_CELLS));
	assign mar_ok    = !mar_q[WORD_W-1] && (mar_q < 32'(MEM_CELLS));
	assign mul_lo    = acc_q * mbr_q;

	assign out_free  = !out_valid_q || res_ready;
	assign clearing  = (state_q == S_CLEAR);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// sequencer and execute
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		acc_d      = acc_q;
		mar_d      = mar_q;
		mbr_d      = mbr_q;
		pop        = 1'b0;
		issue      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = clr_cnt_q;
		mem_wd_opc = '0;
		mem_wd_arg = '0;
		res_load   = 1'b0;
		advance    = 1'b1;
		res_d      = '{halted: 1'b0, status: STAT_OK, op: '0, pc: pc_q, acc: acc_q};
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == AW'(MEM_CELLS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					if (!head.is_step) begin
						// cell write
						mem_we     = head.wr_ok;
						mem_wa     = AW'(head.addr);
						mem_wd_opc = head.opc;
						mem_wd_arg = head.arg;
						res_load   = 1'b1;
					end else if (!fetch_ok) begin
						// fetch beyond the store acts as exit
						res_d.halted = 1'b1;
						res_d.status = STAT_FETCH;
						res_load     = 1'b1;
					end else begin
						issue   = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					case (rd_op_q)
						OP_EXIT: begin
							res_d.halted = 1'b1;
							advance      = 1'b0;
						end
						OP_LOAD_ARG: acc_d = rd_arg_q;
						OP_AC_MBR:   acc_d = mbr_q;
						OP_AC_MAR:   acc_d = mar_q;
						OP_MBR_AC:   mbr_d = acc_q;
						OP_MAR_AC:   mar_d = acc_q;
						OP_MEM_LOAD: begin
							if (mar_ok)
								mbr_d = rd_dat_q;
							else
								res_d.status = STAT_LOAD;
						end
						OP_MEM_STORE: begin
							if (mar_ok) begin
								mem_we     = 1'b1;
								mem_wa     = mar_q[AW-1:0];
								mem_wd_opc = mbr_q;
							end else begin
								res_d.status = STAT_STORE;
							end
						end
						OP_ADD: acc_d = acc_q + mbr_q;
						OP_MUL: acc_d = mul_lo;
						OP_AND: acc_d = {31'd0, (acc_q != '0) && (mbr_q != '0)};
						OP_OR:  acc_d = {31'd0, (acc_q != '0) || (mbr_q != '0)};
						OP_JUMP_NZ: begin
							if (acc_q != '0) begin
								pc_d    = rd_arg_q;
								advance = 1'b0;
							end
						end
						OP_NOP: ;
						default: res_d.status = STAT_UNKNOWN;
					endcase
					if (advance)
						pc_d = pc_q + 1'b1;
					res_d.op  = rd_op_q;
					res_d.pc  = pc_d;
					res_d.acc = acc_d;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state, machine registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			base_q      <= '0;
			pc_q        <= '0;
			acc_q       <= '0;
			mar_q       <= '0;
			mbr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			acc_q <= acc_d;
			mar_q <= mar_d;
			mbr_q <= mbr_d;
			if (cfg_wen) begin
				base_q <= cfg_wdata;
				pc_q   <= '0;
			end else begin
				pc_q <= pc_d;
			end
			if (res_load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load)
			out_q <= res_d;
	end

	// store write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			opc_mem[mem_wa] <= mem_wd_opc;
			arg_mem[mem_wa] <= mem_wd_arg;
		end
	end

	// store read ports: instruction cell and data cell at MAR
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_op_q  <= opc_mem[fetch_sum[AW-1:0]];
			rd_arg_q <= arg_mem[fetch_sum[AW-1:0]];
			rd_dat_q <= opc_mem[mar_q[AW-1:0]];
		end
	end

endmodule

### src/accumulator_cpu_fetch_execute.sv
// Accumulator machine with a built-in store of MEM_CELLS two-word cells. Each input
// request either writes one cell (req_type 0) or runs one fetch-execute step (req_type 1),
// and each request gives exactly one result. A cell write is done straight from the idle
// state; a step first reads the instruction cell and the data cell at MAR from the store's
// registered read ports and then executes in the execute state. A two-entry queue sits
// between the input side and the execute side, and a result register lets the next request
// be taken while a result waits. After reset the store is cleared, one cell per cycle;
// no request is accepted until then, while base_address writes are taken at any time.
// Writing base_address also clears the program counter.
module accumulator_cpu_fetch_execute #(
	parameter int MEM_CELLS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [acf_pkg::CELL_AW-1:0]    cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: cell_address[9:0], cell_opcode[41:10], cell_argument[73:42], zero pad
	input  logic [acf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: req_type[0]
	input  logic [0:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata: halted[0], status[3:1], executed_opcode[35:4], program_counter[67:36],
	// accumulator[99:68], zero pad
	output logic [acf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import acf_pkg::*;

	acf_front_ctl_t front_ctl;
	acf_req_t       push_req, head;
	logic           push, pop, q_full, q_empty, clearing;
	acf_res_t       res;

	assign front_ctl.queue_full = q_full;
	assign front_ctl.clearing   = clearing;

	// input side
	acf_front #(.MEM_CELLS(MEM_CELLS)) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctl           (front_ctl),
		.push          (push),
		.req           (push_req)
	);

	// request queue
	acf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// execute side
	acf_back #(.MEM_CELLS(MEM_CELLS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.clearing  (clearing),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// pack the result
	assign m_axis_tdata = {4'd0, res.acc, res.pc, res.op, res.status, res.halted};

endmodule

### src/acf_checker.sv
// port checker for the accumulator machine, bound to the top level
// depends on acf_pkg
module acf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [acf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import acf_pkg::*;

	logic                halted;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   op;

	assign halted = m_axis_tdata[0];
	assign status = m_axis_tdata[3:1];
	assign op     = m_axis_tdata[35:4];

	// a result that is not taken stays unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// status code stays within the defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (status == STAT_OK || status == STAT_FETCH ||
			status == STAT_LOAD || status == STAT_STORE || status == STAT_UNKNOWN))
		else $error("undefined status code");

	// a halt comes from exit or a failed fetch only
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && halted |-> (status == STAT_FETCH) ||
			(status == STAT_OK && op == OP_EXIT))
		else $error("halt without exit or fetch fault");

	// a fetch fault always halts and executes nothing
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STAT_FETCH |-> halted && op == '0)
		else $error("fetch fault without halt");

endmodule

bind accumulator_cpu_fetch_execute acf_checker u_acf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for accumulator_cpu_fetch_execute: streams cell writes and steps,
// predicts every result with a local copy of the machine and compares them in order
// depends on acf_pkg and the accumulator_cpu_fetch_execute top level
module testbench;
	import acf_pkg::*;

	localparam int MEM_CELLS   = 1024;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_SHOWN   = 10;

	// one request as queued for the driver
	typedef struct {
		logic               kind;
		logic [CELL_AW-1:0] addr;
		logic [WORD_W-1:0]  opc;
		logic [WORD_W-1:0]  arg;
	} cpu_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CELL_AW-1:0]    cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata: cell_address[9:0], cell_opcode[41:10], cell_argument[73:42], zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// tuser: req_type[0]
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata: halted[0], status[3:1], executed_opcode[35:4], program_counter[67:36],
	// accumulator[99:68], zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// machine copy
	logic [WORD_W-1:0]  mem_op [MEM_CELLS];
	logic [WORD_W-1:0]  mem_arg [MEM_CELLS];
	logic [WORD_W-1:0]  m_pc = '0;
	logic [WORD_W-1:0]  m_ac = '0;
	logic [WORD_W-1:0]  m_mar = '0;
	logic [WORD_W-1:0]  m_mbr = '0;
	logic [CELL_AW-1:0] m_base = '0;

	cpu_req_t req_queue[$];
	acf_res_t results_due[$];

	int n_pushed = 0;
	int n_taken = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_steps = 0;
	int n_writes = 0;
	int n_bases = 0;
	int n_halts = 0;
	int n_faults = 0;
	int stall_cycles = 0;

	bit          quiet_in = 1'b0;
	bit          quiet_out = 1'b0;
	bit          in_taken = 1'b0;
	bit          out_taken = 1'b0;
	bit          gap_set = 1'b0;
	bit          stall_set = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	accumulator_cpu_fetch_execute i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned wait_cycles(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// one step of the machine, or one cell write, and its result
	task automatic step_machine(input logic kind, input logic [CELL_AW-1:0] addr,
			input logic [WORD_W-1:0] opc, input logic [WORD_W-1:0] arg);
		acf_res_t   r;
		longint     fetch_at;
		longint     data_at;
		logic [WORD_W-1:0] op;
		logic [WORD_W-1:0] ca;
		logic       adv;
		r.halted = 1'b0;
		r.status = STAT_OK;
		r.op = '0;
		adv = 1'b1;
		if (kind == REQ_WRITE) begin
			mem_op[addr] = opc;
			mem_arg[addr] = arg;
		end else begin
			fetch_at = longint'(m_base) + longint'($signed(m_pc));
			if (fetch_at < 0 || fetch_at >= MEM_CELLS) begin
				// fetch outside the store behaves as exit
				r.halted = 1'b1;
				r.status = STAT_FETCH;
			end else begin
				op = mem_op[int'(fetch_at)];
				ca = mem_arg[int'(fetch_at)];
				r.op = op;
				data_at = longint'($signed(m_mar));
				case (op)
					OP_EXIT: begin
						r.halted = 1'b1;
						adv = 1'b0;
					end
					OP_LOAD_ARG: m_ac = ca;
					OP_AC_MBR:   m_ac = m_mbr;
					OP_AC_MAR:   m_ac = m_mar;
					OP_MBR_AC:   m_mbr = m_ac;
					OP_MAR_AC:   m_mar = m_ac;
					OP_MEM_LOAD: begin
						if (data_at >= 0 && data_at < MEM_CELLS)
							m_mbr = mem_op[int'(data_at)];
						else
							r.status = STAT_LOAD;
					end
					OP_MEM_STORE: begin
						if (data_at >= 0 && data_at < MEM_CELLS) begin
							mem_op[int'(data_at)] = m_mbr;
							mem_arg[int'(data_at)] = '0;
						end else begin
							r.status = STAT_STORE;
						end
					end
					OP_ADD: m_ac = m_ac + m_mbr;
					OP_MUL: m_ac = m_ac * m_mbr;
					OP_AND: m_ac = (m_ac != 0 && m_mbr != 0) ? 32'd1 : 32'd0;
					OP_OR:  m_ac = (m_ac != 0 || m_mbr != 0) ? 32'd1 : 32'd0;
					OP_JUMP_NZ: begin
						if (m_ac != 0) begin
							m_pc = ca;
							adv = 1'b0;
						end
					end
					OP_NOP: ;
					default: r.status = STAT_UNKNOWN;
				endcase
				if (adv)
					m_pc = m_pc + 32'd1;
			end
		end
		if (r.halted)
			n_halts++;
		if (r.status != STAT_OK)
			n_faults++;
		r.pc = m_pc;
		r.acc = m_ac;
		results_due.push_back(r);
	endtask

	task automatic push_req(input logic kind, input logic [CELL_AW-1:0] addr,
			input logic [WORD_W-1:0] opc, input logic [WORD_W-1:0] arg);
		cpu_req_t it;
		it.kind = kind;
		it.addr = addr;
		it.opc = opc;
		it.arg = arg;
		req_queue.push_back(it);
		n_pushed++;
	endtask

	// argument word: mostly small, some extremes, some anything
	function automatic logic [WORD_W-1:0] pick_word(input int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, span);
		if (r < 7) begin
			case ($urandom_range(0, 3))
				0:       return 32'h8000_0000;
				1:       return 32'h7fff_ffff;
				2:       return 32'hffff_ffff;
				default: return MEM_CELLS;
			endcase
		end
		return $urandom;
	endfunction

	// random instruction, known opcodes most of the time
	task automatic make_instr(input int unsigned span, output logic [WORD_W-1:0] opc,
			output logic [WORD_W-1:0] arg);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			opc = OP_EXIT;
		else if (r < 88)
			opc = $urandom_range(OP_LOAD_ARG, OP_NOP);
		else if (r < 94)
			opc = $urandom_range(OP_NOP + 1, OP_NOP + 2);
		else begin
			opc = $urandom;
			if (opc <= OP_NOP)
				opc[WORD_W-1] = 1'b1;
		end
		if (opc == OP_JUMP_NZ)
			arg = pick_word(span);
		else if (opc == OP_LOAD_ARG)
			arg = pick_word(MEM_CELLS - 1);
		else
			arg = $urandom;
	endtask

	// base write once everything in flight has come back
	task automatic set_base(input logic [CELL_AW-1:0] value);
		while (n_taken != n_pushed || results_due.size() != 0)
			@(negedge clk);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		n_bases++;
	endtask

	// model update on accepted requests and base writes
	always @(posedge clk) begin
		if (arst_n && cfg_wen) begin
			m_base = cfg_wdata;
			m_pc = '0;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			in_taken = 1'b1;
			n_taken++;
			if (s_axis_tuser[0] == REQ_STEP)
				n_steps++;
			else
				n_writes++;
			step_machine(s_axis_tuser[0], s_axis_tdata[9:0], s_axis_tdata[41:10],
				s_axis_tdata[73:42]);
		end
	end

	// request driver with a random gap before each request
	always @(negedge clk) begin : drive_proc
		logic     next_valid;
		cpu_req_t it;
		next_valid = s_axis_tvalid;
		if (in_taken) begin
			next_valid = 1'b0;
			in_taken = 1'b0;
		end
		if (arst_n && !next_valid && req_queue.size() != 0) begin
			if (!gap_set) begin
				gap_left = wait_cycles(quiet_in);
				gap_set = 1'b1;
			end
			if (gap_left == 0) begin
				it = req_queue.pop_front();
				gap_set = 1'b0;
				s_axis_tdata <= {6'b0, it.arg, it.opc, it.addr};
				s_axis_tuser <= it.kind;
				next_valid = 1'b1;
			end else begin
				gap_left--;
			end
		end
		s_axis_tvalid <= next_valid;
	end

	// result side ready with a random stall before each result
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			stall_set = 1'b0;
		end
		if (arst_n && !stall_set) begin
			stall_left = wait_cycles(quiet_out);
			stall_set = 1'b1;
		end
		if (arst_n && stall_left == 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			if (m_axis_tvalid && stall_left != 0)
				stall_left--;
		end
	end

	// result checker
	always @(posedge clk) begin : check_proc
		acf_res_t got;
		acf_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			out_taken = 1'b1;
			n_results++;
			got.halted = m_axis_tdata[0];
			got.status = m_axis_tdata[3:1];
			got.op = m_axis_tdata[35:4];
			got.pc = m_axis_tdata[67:36];
			got.acc = m_axis_tdata[99:68];
			if (results_due.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_SHOWN)
					$display("result %0d arrived with nothing pending", n_results);
			end else begin
				want = results_due.pop_front();
				if (got.halted !== want.halted || got.status !== want.status ||
						got.op !== want.op || got.pc !== want.pc || got.acc !== want.acc) begin
					n_errors++;
					if (n_errors <= MAX_SHOWN) begin
						$display("result %0d expected: halted=%0d status=%0d op=%h pc=%h ac=%h",
							n_results, want.halted, want.status, want.op, want.pc, want.acc);
						$display("result %0d actual:   halted=%0d status=%0d op=%h pc=%h ac=%h",
							n_results, got.halted, got.status, got.op, got.pc, got.acc);
					end
				end
			end
		end
	end

	// watchdog on cycles where no request and no result moves
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles, %0d results pending",
				STALL_LIMIT, results_due.size());
			$display("** accumulator_cpu_fetch_execute: FAILED **");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		int unsigned       span;
		int unsigned       ph;
		logic [WORD_W-1:0] opc;
		logic [WORD_W-1:0] arg;
		logic [CELL_AW-1:0] b;
		for (int i = 0; i < MEM_CELLS; i++) begin
			mem_op[i] = '0;
			mem_arg[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_base(10'd0);

		// directed program: moves, memory traffic, faults, wrap, jump out of the store
		push_req(REQ_WRITE, 10'd0, OP_LOAD_ARG, 32'd6);
		push_req(REQ_WRITE, 10'd1, OP_MAR_AC, 32'h0);
		push_req(REQ_WRITE, 10'd2, OP_MEM_LOAD, 32'hffff_ffff);
		push_req(REQ_WRITE, 10'd3, OP_MUL, 32'h0);
		push_req(REQ_WRITE, 10'd4, OP_ADD, 32'h0);
		push_req(REQ_WRITE, 10'd5, OP_MEM_STORE, 32'h0);
		push_req(REQ_WRITE, 10'd6, 32'hffff_ffff, 32'h7fff_ffff);
		push_req(REQ_WRITE, 10'd7, OP_MAR_AC, 32'h0);
		push_req(REQ_WRITE, 10'd8, OP_MEM_LOAD, 32'h0);
		push_req(REQ_WRITE, 10'd9, OP_MEM_STORE, 32'h0);
		push_req(REQ_WRITE, 10'd10, OP_JUMP_NZ, 32'h8000_0000);
		repeat (12)
			push_req(REQ_STEP, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
		// top cell is still cleared, so this is exit, and exit does not move on
		set_base(10'd1023);
		repeat (2)
			push_req(REQ_STEP, 10'h0, 32'h0, 32'h0);

		// random programs, each under its own base
		ph = 0;
		while (n_pushed < 925) begin
			case (ph % 5)
				0:       b = 10'd0;
				1:       b = 10'd1023 - 10'($urandom_range(0, 8));
				default: b = 10'($urandom);
			endcase
			set_base(b);
			quiet_in = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			span = $urandom_range(4, 16);
			for (int i = 0; i < span; i++) begin
				make_instr(span, opc, arg);
				push_req(REQ_WRITE, b + 10'(i), opc, arg);
			end
			repeat (2)
				push_req(REQ_WRITE, 10'($urandom), $urandom, $urandom);
			repeat ($urandom_range(12, 28)) begin
				// occasional patch of the program or a stray write
				if ($urandom_range(0, 99) < 12) begin
					if ($urandom_range(0, 1)) begin
						make_instr(span, opc, arg);
						push_req(REQ_WRITE, b + 10'($urandom_range(0, span - 1)), opc, arg);
					end else begin
						push_req(REQ_WRITE, 10'($urandom), $urandom, $urandom);
					end
				end
				push_req(REQ_STEP, 10'($urandom), $urandom, $urandom);
			end
			ph++;
		end

		// drain
		while (n_taken != n_pushed || results_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d steps and %0d cell writes under %0d base settings",
			n_steps, n_writes, n_bases);
		$display("%0d results checked, %0d halted, %0d with a fault status, %0d errors",
			n_results, n_halts, n_faults, n_errors);
		if (n_errors == 0)
			$display("** accumulator_cpu_fetch_execute: PASSED **");
		else
			$display("** accumulator_cpu_fetch_execute: FAILED **");
		$finish;
	end

endmodule
